// File: sv/sac_pkg.sv
// Shared constants and types for the swept box collision side unit.
`default_nettype none

package sac_pkg;

  localparam int DEF_COORD_BITS = 32;
  localparam int DEF_ID_BITS    = 16;
  localparam int MASK_BITS      = 64;
  localparam int CFG_BITS       = 31;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int PROD_FULL_BITS = 2 * CFG_BITS;
  localparam int PROD_FRAC_BITS = 16;
  localparam int PROD_BITS      = PROD_FULL_BITS - PROD_FRAC_BITS;

  localparam logic [CFG_BITS-1:0]  ONE_Q16       = CFG_BITS'(65536);
  localparam logic [PROD_BITS-1:0] PROD_ONE_Q16  = PROD_BITS'(65536);

  // Command codes carried by the input item.
  localparam logic CMD_TEST  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_LEFT   = 3'd1,
    SIDE_RIGHT  = 3'd2,
    SIDE_TOP    = 3'd3,
    SIDE_BOTTOM = 3'd4
  } side_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ENABLED      = 3'd0,
    CFG_LAYER_MASK   = 3'd1,
    CFG_SCALE_X      = 3'd2,
    CFG_SCALE_Y      = 3'd3,
    CFG_EXTENT_LEFT  = 3'd4,
    CFG_EXTENT_RIGHT = 3'd5,
    CFG_EXTENT_DOWN  = 3'd6,
    CFG_EXTENT_UP    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PSEL_LEFT  = 2'd0,
    PSEL_RIGHT = 2'd1,
    PSEL_DOWN  = 2'd2,
    PSEL_UP    = 2'd3
  } prod_sel_t;

  // Outcome of one pass of the overlap test.
  typedef struct packed {
    logic  overlap;
    side_t side;
  } pass_flags_t;

endpackage

`default_nettype wire

// File: sv/sac_pass.sv
// One overlap pass: moving box bounds, overlap test, intersection center and side.
`default_nettype none

module sac_pass #(
  parameter int COORD_BITS = sac_pkg::DEF_COORD_BITS,
  parameter int PROD_BITS  = sac_pkg::PROD_BITS
) (
  input  wire logic signed [COORD_BITS-1:0] pos_x,
  input  wire logic signed [COORD_BITS-1:0] pos_y,
  input  wire logic signed [COORD_BITS-1:0] omin_x,
  input  wire logic signed [COORD_BITS-1:0] omax_x,
  input  wire logic signed [COORD_BITS-1:0] omin_y,
  input  wire logic signed [COORD_BITS-1:0] omax_y,
  input  wire logic        [PROD_BITS-1:0]  prod_l,
  input  wire logic        [PROD_BITS-1:0]  prod_r,
  input  wire logic        [PROD_BITS-1:0]  prod_d,
  input  wire logic        [PROD_BITS-1:0]  prod_u,
  output sac_pkg::pass_flags_t              flags,
  output logic signed      [COORD_BITS-1:0] pt_x,
  output logic signed      [COORD_BITS-1:0] pt_y
);

  localparam int SW = ((COORD_BITS > PROD_BITS) ? COORD_BITS : PROD_BITS) + 2;
  localparam int DW = COORD_BITS + 1;
  localparam logic signed [SW-1:0] CMAX =
    {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN =
    {{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  function automatic logic signed [SW-1:0] pos_ext(input logic signed [COORD_BITS-1:0] v);
    pos_ext = {{(SW-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] prod_ext(input logic [PROD_BITS-1:0] v);
    prod_ext = {{(SW-PROD_BITS){1'b0}}, v};
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SW-1:0] v);
    if (v > CMAX) begin
      sat = CMAX[COORD_BITS-1:0];
    end else if (v < CMIN) begin
      sat = CMIN[COORD_BITS-1:0];
    end else begin
      sat = v[COORD_BITS-1:0];
    end
  endfunction

  function automatic logic signed [DW-1:0] dext(input logic signed [COORD_BITS-1:0] v);
    dext = {v[COORD_BITS-1], v};
  endfunction

  logic signed [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
  logic signed [COORD_BITS-1:0] ix1, ix2, iy1, iy2;
  logic signed [DW-1:0]         sum_x, sum_y;
  logic signed [DW-1:0]         dl, dr, dt, db;

  always_comb begin
    min_x = sat(pos_ext(pos_x) - prod_ext(prod_l));
    max_x = sat(pos_ext(pos_x) + prod_ext(prod_r));
    min_y = sat(pos_ext(pos_y) - prod_ext(prod_d));
    max_y = sat(pos_ext(pos_y) + prod_ext(prod_u));

    flags.overlap = (min_x <= omax_x) && (max_x >= omin_x) &&
                    (min_y <= omax_y) && (max_y >= omin_y);

    ix1 = (min_x > omin_x) ? min_x : omin_x;
    ix2 = (max_x < omax_x) ? max_x : omax_x;
    iy1 = (min_y > omin_y) ? min_y : omin_y;
    iy2 = (max_y < omax_y) ? max_y : omax_y;

    // The sum carries one extra bit, so dropping its low bit is a floor halving.
    sum_x = dext(ix1) + dext(ix2);
    sum_y = dext(iy1) + dext(iy2);
    pt_x  = sum_x[DW-1:1];
    pt_y  = sum_y[DW-1:1];

    dl = dext(omax_x) - dext(min_x);
    dr = dext(max_x) - dext(omin_x);
    dt = dext(omax_y) - dext(min_y);
    db = dext(max_y) - dext(omin_y);

    if (dl <= dr && dl <= dt && dl <= db) begin
      flags.side = sac_pkg::SIDE_LEFT;
    end else if (dr <= dt && dr <= db) begin
      flags.side = sac_pkg::SIDE_RIGHT;
    end else if (dt <= db) begin
      flags.side = sac_pkg::SIDE_TOP;
    end else begin
      flags.side = sac_pkg::SIDE_BOTTOM;
    end
  end

endmodule

`default_nettype wire

// File: sv/swept_aabb_collision_side_unit.sv
// Swept box collision side unit: top level with config, handshake and sticky pass state.
//
// Each input transfer either tests the moving box against one other box or
// clears both sticky hit flags. A test (if enabled and layer-matched) runs an X
// pass (new x, old y) and a Y pass (old x, new y); each pass, unless its flag is
// already set, records hit, partner id, intersection center and least-penetration side.
// Every input transfer yields exactly one output transfer carrying the state
// of both passes after that item.
// The item is registered at the accepting edge, and the result is registered
// in the pass state registers when the result stage is free to take it.
// Throughput is one item per cycle unless stalled, set by the single compute
// stage between the input register and the pass state registers.
// The input register and the result register form a two-entry pipeline: a
// stalled receiver holds the result, and in_ready drops when both stages
// are full, and also while a configuration write is offered or a sweep runs.
// A configuration write to any register starts a sweep of one shared 31x31
// multiplier that refreshes the four scale-times-extent terms in turn; in_ready
// is low while a write is offered and during the sweep. cfg_ready is high.
// Reset clears both pipeline stages and all pass state and loads defaults.
`default_nettype none

module swept_aabb_collision_side_unit #(
  parameter int COORD_BITS = sac_pkg::DEF_COORD_BITS,
  parameter int ID_BITS    = sac_pkg::DEF_ID_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sac_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [sac_pkg::CFG_DATA_BITS-1:0]   cfg_data,

  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_cmd,
  input  wire logic signed [COORD_BITS-1:0]        in_self_old_x,
  input  wire logic signed [COORD_BITS-1:0]        in_self_old_y,
  input  wire logic signed [COORD_BITS-1:0]        in_self_new_x,
  input  wire logic signed [COORD_BITS-1:0]        in_self_new_y,
  input  wire logic signed [COORD_BITS-1:0]        in_other_min_x,
  input  wire logic signed [COORD_BITS-1:0]        in_other_max_x,
  input  wire logic signed [COORD_BITS-1:0]        in_other_min_y,
  input  wire logic signed [COORD_BITS-1:0]        in_other_max_y,
  input  wire logic [sac_pkg::MASK_BITS-1:0]       in_other_layer,
  input  wire logic [ID_BITS-1:0]                  in_other_id,

  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_x_hit,
  output logic [ID_BITS-1:0]                       out_x_partner,
  output logic signed [COORD_BITS-1:0]             out_x_point_x,
  output logic signed [COORD_BITS-1:0]             out_x_point_y,
  output logic [2:0]                               out_x_side,
  output logic                                     out_y_hit,
  output logic [ID_BITS-1:0]                       out_y_partner,
  output logic signed [COORD_BITS-1:0]             out_y_point_x,
  output logic signed [COORD_BITS-1:0]             out_y_point_y,
  output logic [2:0]                               out_y_side
);

  localparam int PB = sac_pkg::PROD_BITS;
  localparam int CB = sac_pkg::CFG_BITS;

  // Configuration registers.
  logic                           enabled_r;
  logic [sac_pkg::MASK_BITS-1:0]  mask_r;
  logic [CB-1:0]                  scale_x_r, scale_y_r;
  logic [CB-1:0]                  ext_l_r, ext_r_r, ext_d_r, ext_u_r;

  // Scaled extents and the sweep that refreshes them.
  logic [PB-1:0]                  prod_l_r, prod_r_r, prod_d_r, prod_u_r;
  logic                           busy_r, busy_nxt;
  sac_pkg::prod_sel_t             sel_r, sel_nxt;
  logic [CB-1:0]                  mul_a, mul_b;
  logic [sac_pkg::PROD_FULL_BITS-1:0] mul_full;
  logic [PB-1:0]                  mul_prod;

  // Input stage.
  logic                           a_valid_r;
  logic                           a_cmd_r;
  logic signed [COORD_BITS-1:0]   a_old_x_r, a_old_y_r, a_new_x_r, a_new_y_r;
  logic signed [COORD_BITS-1:0]   a_omin_x_r, a_omax_x_r, a_omin_y_r, a_omax_y_r;
  logic [sac_pkg::MASK_BITS-1:0]  a_layer_r;
  logic [ID_BITS-1:0]             a_id_r;

  // Result stage, which is also the sticky pass state.
  logic                           out_valid_r;
  logic                           xh_r, yh_r;
  logic [ID_BITS-1:0]             xp_r, yp_r;
  logic signed [COORD_BITS-1:0]   xpx_r, xpy_r, ypx_r, ypy_r;
  sac_pkg::side_t                 xs_r, ys_r;

  logic                           cfg_fire, in_fire, move, test_go;
  sac_pkg::pass_flags_t           xf, yf;
  logic signed [COORD_BITS-1:0]   xf_px, xf_py, yf_px, yf_py;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign move      = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !busy_r && !cfg_valid && (!a_valid_r || move);
  assign in_fire   = in_valid && in_ready;
  assign test_go   = (a_cmd_r == sac_pkg::CMD_TEST) && enabled_r &&
                     (|(mask_r & a_layer_r));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      mask_r    <= '0;
      scale_x_r <= sac_pkg::ONE_Q16;
      scale_y_r <= sac_pkg::ONE_Q16;
      ext_l_r   <= sac_pkg::ONE_Q16;
      ext_r_r   <= sac_pkg::ONE_Q16;
      ext_d_r   <= sac_pkg::ONE_Q16;
      ext_u_r   <= sac_pkg::ONE_Q16;
    end else if (cfg_fire) begin
      case (sac_pkg::cfg_reg_t'(cfg_index))
        sac_pkg::CFG_ENABLED:      enabled_r <= cfg_data[0];
        sac_pkg::CFG_LAYER_MASK:   mask_r    <= cfg_data;
        sac_pkg::CFG_SCALE_X:      scale_x_r <= cfg_data[CB-1:0];
        sac_pkg::CFG_SCALE_Y:      scale_y_r <= cfg_data[CB-1:0];
        sac_pkg::CFG_EXTENT_LEFT:  ext_l_r   <= cfg_data[CB-1:0];
        sac_pkg::CFG_EXTENT_RIGHT: ext_r_r   <= cfg_data[CB-1:0];
        sac_pkg::CFG_EXTENT_DOWN:  ext_d_r   <= cfg_data[CB-1:0];
        sac_pkg::CFG_EXTENT_UP:    ext_u_r   <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // Product sweep: one scale-times-extent term per cycle after any write; a further write restarts it.
  always_comb begin
    busy_nxt = busy_r;
    sel_nxt  = sel_r;
    if (cfg_fire) begin
      busy_nxt = 1'b1;
      sel_nxt  = sac_pkg::PSEL_LEFT;
    end else if (busy_r) begin
      sel_nxt = sac_pkg::prod_sel_t'(sel_r + 2'd1);
      if (sel_r == sac_pkg::PSEL_UP) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    case (sel_r)
      sac_pkg::PSEL_LEFT:  begin mul_a = scale_x_r; mul_b = ext_l_r; end
      sac_pkg::PSEL_RIGHT: begin mul_a = scale_x_r; mul_b = ext_r_r; end
      sac_pkg::PSEL_DOWN:  begin mul_a = scale_y_r; mul_b = ext_d_r; end
      sac_pkg::PSEL_UP:    begin mul_a = scale_y_r; mul_b = ext_u_r; end
      default:             begin mul_a = scale_x_r; mul_b = ext_l_r; end
    endcase
    mul_full = {{CB{1'b0}}, mul_a} * {{CB{1'b0}}, mul_b};
    mul_prod = mul_full[sac_pkg::PROD_FULL_BITS-1:sac_pkg::PROD_FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      sel_r    <= sac_pkg::PSEL_LEFT;
      prod_l_r <= sac_pkg::PROD_ONE_Q16;
      prod_r_r <= sac_pkg::PROD_ONE_Q16;
      prod_d_r <= sac_pkg::PROD_ONE_Q16;
      prod_u_r <= sac_pkg::PROD_ONE_Q16;
    end else begin
      busy_r <= busy_nxt;
      sel_r  <= sel_nxt;
      if (busy_r && !cfg_fire) begin
        case (sel_r)
          sac_pkg::PSEL_LEFT:  prod_l_r <= mul_prod;
          sac_pkg::PSEL_RIGHT: prod_r_r <= mul_prod;
          sac_pkg::PSEL_DOWN:  prod_d_r <= mul_prod;
          sac_pkg::PSEL_UP:    prod_u_r <= mul_prod;
          default: ;
        endcase
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_cmd_r    <= in_cmd;
      a_old_x_r  <= in_self_old_x;
      a_old_y_r  <= in_self_old_y;
      a_new_x_r  <= in_self_new_x;
      a_new_y_r  <= in_self_new_y;
      a_omin_x_r <= in_other_min_x;
      a_omax_x_r <= in_other_max_x;
      a_omin_y_r <= in_other_min_y;
      a_omax_y_r <= in_other_max_y;
      a_layer_r  <= in_other_layer;
      a_id_r     <= in_other_id;
    end
  end

  sac_pass #(
    .COORD_BITS (COORD_BITS),
    .PROD_BITS  (PB)
  ) u_xpass (
    .pos_x  (a_new_x_r),
    .pos_y  (a_old_y_r),
    .omin_x (a_omin_x_r),
    .omax_x (a_omax_x_r),
    .omin_y (a_omin_y_r),
    .omax_y (a_omax_y_r),
    .prod_l (prod_l_r),
    .prod_r (prod_r_r),
    .prod_d (prod_d_r),
    .prod_u (prod_u_r),
    .flags  (xf),
    .pt_x   (xf_px),
    .pt_y   (xf_py)
  );

  sac_pass #(
    .COORD_BITS (COORD_BITS),
    .PROD_BITS  (PB)
  ) u_ypass (
    .pos_x  (a_old_x_r),
    .pos_y  (a_new_y_r),
    .omin_x (a_omin_x_r),
    .omax_x (a_omax_x_r),
    .omin_y (a_omin_y_r),
    .omax_y (a_omax_y_r),
    .prod_l (prod_l_r),
    .prod_r (prod_r_r),
    .prod_d (prod_d_r),
    .prod_u (prod_u_r),
    .flags  (yf),
    .pt_x   (yf_px),
    .pt_y   (yf_py)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Pass state update; a pass whose flag is already set keeps everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xh_r  <= 1'b0;
      xp_r  <= '0;
      xpx_r <= '0;
      xpy_r <= '0;
      xs_r  <= sac_pkg::SIDE_NONE;
      yh_r  <= 1'b0;
      yp_r  <= '0;
      ypx_r <= '0;
      ypy_r <= '0;
      ys_r  <= sac_pkg::SIDE_NONE;
    end else if (move) begin
      if (a_cmd_r == sac_pkg::CMD_CLEAR) begin
        xh_r <= 1'b0;
        yh_r <= 1'b0;
      end else if (test_go) begin
        if (!xh_r) begin
          xh_r <= xf.overlap;
          if (xf.overlap) begin
            xp_r  <= a_id_r;
            xpx_r <= xf_px;
            xpy_r <= xf_py;
            xs_r  <= xf.side;
          end else begin
            xp_r <= '0;
          end
        end
        if (!yh_r) begin
          yh_r <= yf.overlap;
          if (yf.overlap) begin
            yp_r  <= a_id_r;
            ypx_r <= yf_px;
            ypy_r <= yf_py;
            ys_r  <= yf.side;
          end else begin
            yp_r <= '0;
          end
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x_hit     = xh_r;
  assign out_x_partner = xp_r;
  assign out_x_point_x = xpx_r;
  assign out_x_point_y = xpy_r;
  assign out_x_side    = xs_r;
  assign out_y_hit     = yh_r;
  assign out_y_partner = yp_r;
  assign out_y_point_x = ypx_r;
  assign out_y_point_y = ypy_r;
  assign out_y_side    = ys_r;

endmodule

`default_nettype wire
